@@ rtl/trigger_sequence_interpreter_unit_macros.svh @@
// Assertion macros shared by the checker of the trigger sequence interpreter.
// Depends on nothing; the including module must provide clk and arst_n.
`ifndef TRIGGER_SEQUENCE_INTERPRETER_UNIT_MACROS_SVH
`define TRIGGER_SEQUENCE_INTERPRETER_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define TSI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TSI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tsi_pkg.sv @@
// Shared types, codes and constants of the trigger sequence interpreter.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps
package tsi_pkg;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_START = 3'd1,
		ACT_STOP  = 3'd2,
		ACT_TIMER = 3'd3,
		ACT_EXEC  = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_OP,
		S_B1,
		S_B2,
		S_MUL,
		S_CMP,
		S_FIN
	} fsm_state_t;

	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_CAMERA = 3'd1;
	localparam logic [2:0] CMD_FLASH  = 3'd2;
	localparam logic [2:0] CMD_PIN_LO = 3'd3;
	localparam logic [2:0] CMD_PIN_HI = 3'd4;
	localparam logic [2:0] CMD_WAIT   = 3'd5;
	localparam logic [2:0] CMD_CANCEL = 3'd6;

	localparam logic [1:0] RS_STOPPED = 2'd0;
	localparam logic [1:0] RS_RUNNING = 2'd1;
	localparam logic [1:0] RS_PAUSED  = 2'd2;

	localparam logic [1:0] CFG_MIN = 2'd0;
	localparam logic [1:0] CFG_MAX = 2'd1;
	localparam logic [1:0] CFG_DEF = 2'd2;

	localparam logic [7:0] OP_CAMERA   = 8'd0;
	localparam logic [7:0] OP_FLASH    = 8'd1;
	localparam logic [7:0] OP_EXP_P3   = 8'd2;
	localparam logic [7:0] OP_EXP_P2   = 8'd3;
	localparam logic [7:0] OP_EXP_M3   = 8'd4;
	localparam logic [7:0] OP_EXP_M2   = 8'd5;
	localparam logic [7:0] OP_SET_SH   = 8'd6;
	localparam logic [7:0] OP_PIN_LO   = 8'd7;
	localparam logic [7:0] OP_PIN_HI   = 8'd8;
	localparam logic [7:0] OP_WAIT_NS  = 8'd9;
	localparam logic [7:0] OP_WAIT_US  = 8'd10;
	localparam logic [7:0] OP_WAIT_MS  = 8'd11;
	localparam logic [7:0] OP_WAIT_S   = 8'd12;
	localparam logic [7:0] OP_WAIT_MIN = 8'd13;
	localparam logic [7:0] OP_PWAIT_A  = 8'd14;
	localparam logic [7:0] OP_PWAIT_B  = 8'd15;
	localparam logic [7:0] OP_LOOP     = 8'd16;
	localparam logic [7:0] OP_FOREVER  = 8'd17;
	localparam logic [7:0] OP_UNT_CNT  = 8'd18;
	localparam logic [7:0] OP_UNT_LO_A = 8'd19;
	localparam logic [7:0] OP_UNT_LO_B = 8'd20;
	localparam logic [7:0] OP_UNT_HI_A = 8'd21;
	localparam logic [7:0] OP_UNT_HI_B = 8'd22;
	localparam logic [7:0] OP_UNT_NS   = 8'd23;
	localparam logic [7:0] OP_UNT_HR   = 8'd28;
	localparam logic [7:0] OP_END      = 8'd29;

	localparam int MUL_BITS = 16;

	// Nanoseconds per unit for the until-time opcodes, ns up to hours.
	localparam logic [41:0] UNIT_NS [6] = '{
		42'd1, 42'd1000, 42'd1000000, 42'd1000000000,
		42'd60000000000, 42'd3600000000000
	};

	function automatic logic is_until_time(input logic [7:0] op);
		return (op >= OP_UNT_NS) && (op <= OP_UNT_HR);
	endfunction

	function automatic logic needs_word(input logic [7:0] op);
		return ((op >= OP_WAIT_NS) && (op <= OP_WAIT_MIN)) || is_until_time(op);
	endfunction

	function automatic logic needs_operand(input logic [7:0] op);
		return (op == OP_SET_SH) || (op == OP_PIN_LO) || (op == OP_PIN_HI) ||
			((op >= OP_UNT_CNT) && (op <= OP_UNT_HI_B)) || needs_word(op);
	endfunction

	function automatic logic [41:0] unit_of(input logic [7:0] op);
		logic [7:0] k;
		k = op - OP_UNT_NS;
		return (k < 8'd6) ? UNIT_NS[k[2:0]] : 42'd0;
	endfunction

endpackage

@@ rtl/tsi_prog_mem.sv @@
// Program byte store with registered read; unwritten bytes read as end of program.
// Depends on tsi_pkg.
`timescale 1ns / 1ps
module tsi_prog_mem #(
	parameter int DEPTH = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       we,
	input  logic [7:0] waddr,
	input  logic [7:0] wdata,
	input  logic [8:0] raddr,
	output logic [7:0] rdata
);
	localparam int AW = $clog2(DEPTH);

	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [7:0]       rd_q;
	logic             hit_q;
	logic             wr_ok;
	logic             rd_ok;

	assign wr_ok = we && (waddr < 8'(DEPTH));
	assign rd_ok = raddr < 9'(DEPTH);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[waddr[AW-1:0]] <= wdata;
		end
		rd_q <= mem[raddr[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				vld_q[waddr[AW-1:0]] <= 1'b1;
			end
			hit_q <= rd_ok && vld_q[raddr[AW-1:0]];
		end
	end

	assign rdata = hit_q ? rd_q : tsi_pkg::OP_END;
endmodule

@@ rtl/tsi_mul.sv @@
// Shift-and-add unit: base plus unit constant times a 16-bit operand, one bit a cycle.
// Depends on tsi_pkg.
`timescale 1ns / 1ps
module tsi_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [63:0] base,
	input  logic [41:0] mcand,
	input  logic [15:0] mplier,
	output logic        done,
	output logic [63:0] result
);
	localparam int CW = $clog2(tsi_pkg::MUL_BITS);

	logic [63:0]   acc_q;
	logic [63:0]   mc_q;
	logic [15:0]   mp_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(tsi_pkg::MUL_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			acc_q <= base;
			mc_q  <= {22'd0, mcand};
			mp_q  <= mplier;
		end else if (busy_q) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[62:0], 1'b0};
			mp_q <= {1'b0, mp_q[15:1]};
		end
	end

	assign done   = done_q;
	assign result = acc_q;
endmodule

@@ rtl/trigger_sequence_interpreter_unit.sv @@
// Top level of the trigger sequence interpreter: command channel, sequencer,
// loop-context stack. Depends on tsi_pkg, tsi_prog_mem and tsi_mul.
//
// Usage: a request is taken when start is high and busy is low. Its action
// writes a program byte, starts, stops, resumes after a timer, or executes
// one opcode. Each request produces exactly one result on command,
// command_arg, wait_count, wait_unit and run_state, marked by done for one
// cycle; the receiver cannot stall and must take it then.
// Configuration (min, max and default shutter index) is written through
// cfg_valid/cfg_index/cfg_data; cfg_ready is always high. The user must make
// writes only while the block is idle; the block itself does not enforce it.
// Non-execute requests pass through DISPATCH and FIN; an executed opcode adds
// OP, then B1 for a byte operand or B1 and B2 for a word operand.
// Until-time opcodes add the compare state CMP, plus MUL the first time a
// context computes its deadline: the shared shift-add unit retires one
// operand bit per cycle. The next request is taken the cycle done rises.
// Every program byte fetch goes through the one registered read port of the
// program store.
// Reset stops the program, clears the loop level and shutter index, and
// makes all program bytes read as end of program.
`timescale 1ns / 1ps
module trigger_sequence_interpreter_unit #(
	parameter int PROGRAM_BYTES = 128,
	parameter int LOOP_DEPTH    = 8,
	parameter int NUM_PINS      = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  prog_addr,
	input  logic [7:0]  prog_byte,
	input  logic [31:0] pin_levels,
	input  logic [62:0] now_ns,
	output logic        done,
	output logic [2:0]  command,
	output logic [7:0]  command_arg,
	output logic [21:0] wait_count,
	output logic [1:0]  wait_unit,
	output logic [1:0]  run_state,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	localparam int LW = $clog2(LOOP_DEPTH);

	tsi_pkg::fsm_state_t state_q, state_d;

	logic [2:0]  act_q;
	logic [7:0]  addr_q;
	logic [7:0]  byte_q;
	logic [31:0] pins_q;
	logic [62:0] now_q;

	logic [7:0]    min_q, max_q, def_q;
	logic [1:0]    exec_q;
	logic [7:0]    ip_q;
	logic [8:0]    wp_q;
	logic [7:0]    sh_q;
	logic [LW-1:0] lvl_q;
	logic          exe_q;
	logic [7:0]    op_q;
	logic [7:0]    b1_q;

	logic [7:0]  sp_q  [LOOP_DEPTH];
	logic [7:0]  cnt_q [LOOP_DEPTH];
	logic [63:0] st_q  [LOOP_DEPTH];
	logic [63:0] dl_q  [LOOP_DEPTH];
	logic [LOOP_DEPTH-1:0] dv_q;

	logic [2:0]  r_cmd_q;
	logic [7:0]  r_arg_q;
	logic [21:0] r_wc_q;
	logic [1:0]  r_wu_q;

	logic [8:0]  raddr;
	logic [7:0]  rdata;
	logic        mem_we;
	logic        mul_go;
	logic        mul_done;
	logic [63:0] mul_res;
	logic [15:0] word;
	logic        pin_lvl;
	logic        ptr_over;
	logic [8:0]  sh_up;
	logic [8:0]  sh_floor;
	logic [7:0]  sh_step;

	assign busy      = (state_q != tsi_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign word      = {b1_q, rdata};
	assign raddr     = (state_q == tsi_pkg::S_DISPATCH) ? {1'b0, ip_q} : wp_q;
	assign mem_we    = (state_q == tsi_pkg::S_DISPATCH) &&
		(act_q == tsi_pkg::ACT_WRITE);
	assign mul_go    = (state_q == tsi_pkg::S_B2) && tsi_pkg::is_until_time(op_q) &&
		!dv_q[lvl_q];
	assign pin_lvl   = (rdata < 8'(NUM_PINS)) && (rdata < 8'd32) && pins_q[rdata[4:0]];
	assign ptr_over  = wp_q >= 9'(PROGRAM_BYTES);

	// Exposure steps: plus three or two saturate at max, minus at min.
	assign sh_step  = ((rdata == tsi_pkg::OP_EXP_P3) || (rdata == tsi_pkg::OP_EXP_M3)) ?
		8'd3 : 8'd2;
	assign sh_up    = {1'b0, sh_q} + {1'b0, sh_step};
	assign sh_floor = {1'b0, min_q} + {1'b0, sh_step};

	tsi_prog_mem #(
		.DEPTH(PROGRAM_BYTES)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (addr_q),
		.wdata (byte_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	tsi_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (mul_go),
		.base  (st_q[lvl_q]),
		.mcand (tsi_pkg::unit_of(op_q)),
		.mplier(word),
		.done  (mul_done),
		.result(mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tsi_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsi_pkg::S_IDLE: begin
				if (start) begin
					state_d = tsi_pkg::S_DISPATCH;
				end
			end
			tsi_pkg::S_DISPATCH: begin
				if ((act_q == tsi_pkg::ACT_EXEC) && (exec_q == tsi_pkg::RS_RUNNING)) begin
					state_d = tsi_pkg::S_OP;
				end else begin
					state_d = tsi_pkg::S_FIN;
				end
			end
			tsi_pkg::S_OP: begin
				state_d = tsi_pkg::needs_operand(rdata) ? tsi_pkg::S_B1 : tsi_pkg::S_FIN;
			end
			tsi_pkg::S_B1: begin
				state_d = tsi_pkg::needs_word(op_q) ? tsi_pkg::S_B2 : tsi_pkg::S_FIN;
			end
			tsi_pkg::S_B2: begin
				if (mul_go) begin
					state_d = tsi_pkg::S_MUL;
				end else if (tsi_pkg::is_until_time(op_q)) begin
					state_d = tsi_pkg::S_CMP;
				end else begin
					state_d = tsi_pkg::S_FIN;
				end
			end
			tsi_pkg::S_MUL: begin
				if (mul_done) begin
					state_d = tsi_pkg::S_CMP;
				end
			end
			tsi_pkg::S_CMP: state_d = tsi_pkg::S_FIN;
			tsi_pkg::S_FIN: state_d = tsi_pkg::S_IDLE;
			default: state_d = tsi_pkg::S_IDLE;
		endcase
	end

	// Request capture and loop-context payload.
	always_ff @(posedge clk) begin
		if ((state_q == tsi_pkg::S_IDLE) && start) begin
			act_q  <= action;
			addr_q <= prog_addr;
			byte_q <= prog_byte;
			pins_q <= pin_levels;
			now_q  <= now_ns;
		end
		if ((state_q == tsi_pkg::S_DISPATCH) && (act_q == tsi_pkg::ACT_START)) begin
			sp_q[0]  <= 8'd0;
			cnt_q[0] <= 8'd0;
			st_q[0]  <= {1'b0, now_q};
		end
		if (state_q == tsi_pkg::S_OP) begin
			op_q <= rdata;
			if ((rdata == tsi_pkg::OP_LOOP) &&
				(({1'b0, lvl_q} + 1'b1) < (LW + 1)'(LOOP_DEPTH))) begin
				sp_q[lvl_q + 1'b1]  <= wp_q[7:0];
				cnt_q[lvl_q + 1'b1] <= 8'd0;
				st_q[lvl_q + 1'b1]  <= {1'b0, now_q};
			end
		end
		if (state_q == tsi_pkg::S_B1) begin
			b1_q <= rdata;
			if (op_q == tsi_pkg::OP_UNT_CNT) begin
				cnt_q[lvl_q] <= cnt_q[lvl_q] + 1'b1;
			end
		end
		if ((state_q == tsi_pkg::S_MUL) && mul_done) begin
			dl_q[lvl_q] <= mul_res;
		end
	end

	// Sequencer control state and the result staging.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= 8'd0;
			max_q       <= 8'd60;
			def_q       <= 8'd30;
			exec_q      <= tsi_pkg::RS_STOPPED;
			ip_q        <= 8'd0;
			wp_q        <= 9'd0;
			sh_q        <= 8'd0;
			lvl_q       <= '0;
			dv_q        <= '0;
			exe_q       <= 1'b0;
			r_cmd_q     <= tsi_pkg::CMD_NONE;
			r_arg_q     <= 8'd0;
			r_wc_q      <= 22'd0;
			r_wu_q      <= 2'd0;
			done        <= 1'b0;
			command     <= tsi_pkg::CMD_NONE;
			command_arg <= 8'd0;
			wait_count  <= 22'd0;
			wait_unit   <= 2'd0;
			run_state   <= tsi_pkg::RS_STOPPED;
		end else begin
			done <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					tsi_pkg::CFG_MIN: min_q <= cfg_data;
					tsi_pkg::CFG_MAX: max_q <= cfg_data;
					tsi_pkg::CFG_DEF: def_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				tsi_pkg::S_DISPATCH: begin
					r_cmd_q <= tsi_pkg::CMD_NONE;
					r_arg_q <= 8'd0;
					r_wc_q  <= 22'd0;
					r_wu_q  <= 2'd0;
					exe_q   <= 1'b0;
					case (act_q)
						tsi_pkg::ACT_START: begin
							sh_q     <= def_q;
							lvl_q    <= '0;
							dv_q[0]  <= 1'b0;
							ip_q     <= 8'd0;
							exec_q   <= tsi_pkg::RS_RUNNING;
						end
						tsi_pkg::ACT_STOP: begin
							r_cmd_q <= tsi_pkg::CMD_CANCEL;
							exec_q  <= tsi_pkg::RS_STOPPED;
						end
						tsi_pkg::ACT_TIMER: begin
							if (exec_q == tsi_pkg::RS_PAUSED) begin
								exec_q <= tsi_pkg::RS_RUNNING;
							end
						end
						tsi_pkg::ACT_EXEC: begin
							if (exec_q == tsi_pkg::RS_RUNNING) begin
								exe_q <= 1'b1;
								wp_q  <= {1'b0, ip_q} + 9'd1;
							end
						end
						default: ;
					endcase
				end
				tsi_pkg::S_OP: begin
					if (tsi_pkg::needs_operand(rdata)) begin
						wp_q <= wp_q + 9'd1;
					end
					case (rdata) inside
						tsi_pkg::OP_CAMERA: begin
							r_cmd_q <= tsi_pkg::CMD_CAMERA;
							r_arg_q <= sh_q;
							exec_q  <= tsi_pkg::RS_PAUSED;
						end
						tsi_pkg::OP_FLASH: begin
							r_cmd_q <= tsi_pkg::CMD_FLASH;
							exec_q  <= tsi_pkg::RS_PAUSED;
						end
						tsi_pkg::OP_EXP_P3, tsi_pkg::OP_EXP_P2: begin
							sh_q <= (sh_up > {1'b0, max_q}) ? max_q : sh_up[7:0];
						end
						tsi_pkg::OP_EXP_M3, tsi_pkg::OP_EXP_M2: begin
							sh_q <= ({1'b0, sh_q} < sh_floor) ? min_q : sh_q - sh_step;
						end
						tsi_pkg::OP_PWAIT_A, tsi_pkg::OP_PWAIT_B: ;
						tsi_pkg::OP_LOOP: begin
							if (({1'b0, lvl_q} + 1'b1) >= (LW + 1)'(LOOP_DEPTH)) begin
								exec_q <= tsi_pkg::RS_STOPPED;
							end else begin
								lvl_q               <= lvl_q + 1'b1;
								dv_q[lvl_q + 1'b1] <= 1'b0;
							end
						end
						tsi_pkg::OP_FOREVER: wp_q <= {1'b0, sp_q[lvl_q]};
						[tsi_pkg::OP_SET_SH:tsi_pkg::OP_WAIT_MIN],
						[tsi_pkg::OP_UNT_CNT:tsi_pkg::OP_UNT_HR]: ;
						default: exec_q <= tsi_pkg::RS_STOPPED;
					endcase
				end
				tsi_pkg::S_B1: begin
					if (tsi_pkg::needs_word(op_q)) begin
						wp_q <= wp_q + 9'd1;
					end
					case (op_q) inside
						tsi_pkg::OP_SET_SH: sh_q <= rdata;
						tsi_pkg::OP_PIN_LO, tsi_pkg::OP_PIN_HI: begin
							r_cmd_q <= (op_q == tsi_pkg::OP_PIN_LO) ?
								tsi_pkg::CMD_PIN_LO : tsi_pkg::CMD_PIN_HI;
							r_arg_q <= rdata;
						end
						tsi_pkg::OP_UNT_CNT: begin
							if (cnt_q[lvl_q] < rdata) begin
								wp_q <= {1'b0, sp_q[lvl_q]};
							end else if (lvl_q == '0) begin
								exec_q <= tsi_pkg::RS_STOPPED;
							end else begin
								lvl_q <= lvl_q - 1'b1;
							end
						end
						[tsi_pkg::OP_UNT_LO_A:tsi_pkg::OP_UNT_HI_B]: begin
							// Low-pin opcodes repeat while the pin is high, and the reverse.
							if (pin_lvl == (op_q <= tsi_pkg::OP_UNT_LO_B)) begin
								wp_q <= {1'b0, sp_q[lvl_q]};
							end else if (lvl_q == '0) begin
								exec_q <= tsi_pkg::RS_STOPPED;
							end else begin
								lvl_q <= lvl_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				tsi_pkg::S_B2: begin
					if (tsi_pkg::is_until_time(op_q)) begin
						dv_q[lvl_q] <= 1'b1;
					end else begin
						r_cmd_q <= tsi_pkg::CMD_WAIT;
						exec_q  <= tsi_pkg::RS_PAUSED;
						if (op_q == tsi_pkg::OP_WAIT_MIN) begin
							r_wc_q <= 22'({word, 6'd0}) - 22'({word, 2'd0});
							r_wu_q <= 2'd3;
						end else begin
							r_wc_q <= {6'd0, word};
							r_wu_q <= 2'(op_q - tsi_pkg::OP_WAIT_NS);
						end
					end
				end
				tsi_pkg::S_CMP: begin
					if (dl_q[lvl_q] > {1'b0, now_q}) begin
						wp_q <= {1'b0, sp_q[lvl_q]};
					end else if (lvl_q == '0) begin
						exec_q <= tsi_pkg::RS_STOPPED;
					end else begin
						lvl_q <= lvl_q - 1'b1;
					end
				end
				tsi_pkg::S_FIN: begin
					done        <= 1'b1;
					command     <= r_cmd_q;
					command_arg <= r_arg_q;
					wait_count  <= r_wc_q;
					wait_unit   <= r_wu_q;
					if (exe_q) begin
						ip_q <= wp_q[7:0];
						if (ptr_over) begin
							exec_q <= tsi_pkg::RS_STOPPED;
						end
					end
					run_state <= (exe_q && ptr_over) ? tsi_pkg::RS_STOPPED : exec_q;
				end
				tsi_pkg::S_IDLE, tsi_pkg::S_MUL: ;
				default: ;
			endcase
		end
	end
endmodule

@@ rtl/tsi_chk.sv @@
// Port-level checker of the trigger sequence interpreter, bound to its top level.
// Depends on tsi_pkg and trigger_sequence_interpreter_unit_macros.svh.
`timescale 1ns / 1ps
`include "trigger_sequence_interpreter_unit_macros.svh"
module tsi_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [2:0] command,
	input logic [1:0] run_state
);
	`TSI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
	`TSI_ASSERT_SAME(a_done_idle, done, !busy, "result shown while still busy")
	`TSI_ASSERT_SAME(a_cancel_stops, done && (command == tsi_pkg::CMD_CANCEL), run_state == tsi_pkg::RS_STOPPED, "cancel without stop")
	`TSI_ASSERT_SAME(a_state_holds, !done, $stable(run_state), "run state changed without a result")
endmodule

bind trigger_sequence_interpreter_unit tsi_chk u_chk (.*);

@@ verif/trigger_sequence_interpreter_unit_tb.sv @@
// Self-checking testbench for the trigger sequence interpreter: directed table, then random
// programs run through start, execute, timer and stop requests under several shutter settings.
// Depends on tsi_pkg and trigger_sequence_interpreter_unit.
`timescale 1ns / 1ps
module trigger_sequence_interpreter_unit_tb;
	import tsi_pkg::*;

	localparam int PROG_BYTES = 128;
	localparam int CTX_DEPTH  = 8;
	localparam int PIN_COUNT  = 32;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_REQS = 1050;

	typedef struct {
		logic [2:0]  act;
		logic [7:0]  addr;
		logic [7:0]  data;
		logic [31:0] pins;
		logic [62:0] now;
	} req_t;

	typedef struct {
		logic [2:0]  cmd;
		logic [7:0]  arg;
		logic [21:0] cnt;
		logic [1:0]  unit;
		logic [1:0]  rs;
	} res_t;

	typedef struct {
		req_t rq;
		bit   typed;
		res_t ex;
	} row_t;

	logic clk, arst_n, start, busy, done, cfg_valid, cfg_ready;
	logic [2:0]  action, command;
	logic [7:0]  prog_addr, prog_byte, command_arg, cfg_data;
	logic [31:0] pin_levels;
	logic [62:0] now_ns;
	logic [21:0] wait_count;
	logic [1:0]  wait_unit, run_state, cfg_index;

	trigger_sequence_interpreter_unit uut (.*);

	// Sequencer state as predicted.
	logic [7:0]      pmem [PROG_BYTES];
	int unsigned     ip, st, sh, lvl;
	int unsigned     lsp [CTX_DEPTH];
	int unsigned     lcnt [CTX_DEPTH];
	longint unsigned lst [CTX_DEPTH];
	longint unsigned ldl [CTX_DEPTH];
	bit              dv [CTX_DEPTH];
	int unsigned     min_idx, max_idx, def_idx;

	localparam longint unsigned NS_PER_UNIT [6] = '{
		64'd1, 64'd1000, 64'd1000000, 64'd1000000000, 64'd60000000000, 64'd3600000000000
	};

	res_t pending_results [$];
	row_t directed [$];
	int errors, results_seen, cycles;
	int reqs_done, programs_run;
	bit quiet;
	longint unsigned now_cur;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("trigger_sequence_interpreter_unit_tb: errors");
			$finish;
		end
	end

	task automatic report(input string what, input longint unsigned exp_v,
			input longint unsigned got_v);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
		errors++;
	endtask

	always @(posedge clk) begin
		res_t e;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report("unexpected result, command", 0, command);
			end else begin
				e = pending_results.pop_front();
				if (command !== e.cmd) report("command", e.cmd, command);
				if (command_arg !== e.arg) report("command_arg", e.arg, command_arg);
				if (wait_count !== e.cnt) report("wait_count", e.cnt, wait_count);
				if (wait_unit !== e.unit) report("wait_unit", e.unit, wait_unit);
				if (run_state !== e.rs) report("run_state", e.rs, run_state);
			end
		end
	end

	function automatic int unsigned byte_at(int unsigned a);
		return a < PROG_BYTES ? pmem[a] : OP_END;
	endfunction

	function automatic int unsigned pin_on(logic [31:0] pins, int unsigned pin);
		if (pin >= PIN_COUNT || pin >= 32) return 0;
		return pins[pin];
	endfunction

	// Either jump back to the start of the current context or leave it.
	function automatic void repeat_or_leave(bit again);
		if (again) ip = lsp[lvl % CTX_DEPTH];
		else if (lvl == 0) st = RS_STOPPED;
		else lvl--;
	endfunction

	function automatic res_t step_sequencer(req_t r);
		res_t o;
		int unsigned op, lv, t, c;
		o = '{default: '0};
		case (r.act)
			ACT_WRITE: if (r.addr < PROG_BYTES) pmem[r.addr] = r.data;
			ACT_START: begin
				sh = def_idx;
				lvl = 0;
				lsp[0] = 0;
				lcnt[0] = 0;
				lst[0] = r.now;
				dv[0] = 0;
				ldl[0] = 0;
				ip = 0;
				st = RS_RUNNING;
			end
			ACT_STOP: begin
				o.cmd = CMD_CANCEL;
				st = RS_STOPPED;
			end
			ACT_TIMER: if (st == RS_PAUSED) st = RS_RUNNING;
			ACT_EXEC: if (st == RS_RUNNING) begin
				op = byte_at(ip);
				ip++;
				lv = lvl % CTX_DEPTH;
				case (op)
					OP_CAMERA: begin
						o.cmd = CMD_CAMERA;
						o.arg = sh;
						st = RS_PAUSED;
					end
					OP_FLASH: begin
						o.cmd = CMD_FLASH;
						st = RS_PAUSED;
					end
					OP_EXP_P3, OP_EXP_P2: begin
						t = sh + (op == OP_EXP_P3 ? 3 : 2);
						sh = t > max_idx ? max_idx : t;
					end
					OP_EXP_M3, OP_EXP_M2: begin
						t = op == OP_EXP_M3 ? 3 : 2;
						sh = sh < min_idx + t ? min_idx : sh - t;
					end
					OP_SET_SH: begin
						sh = byte_at(ip);
						ip++;
					end
					OP_PIN_LO, OP_PIN_HI: begin
						o.cmd = op == OP_PIN_LO ? CMD_PIN_LO : CMD_PIN_HI;
						o.arg = byte_at(ip);
						ip++;
					end
					OP_WAIT_NS, OP_WAIT_US, OP_WAIT_MS, OP_WAIT_S, OP_WAIT_MIN: begin
						t = (byte_at(ip) << 8) | byte_at(ip + 1);
						ip += 2;
						o.cmd = CMD_WAIT;
						if (op == OP_WAIT_MIN) begin
							o.cnt = 60 * t;
							o.unit = 3;
						end else begin
							o.cnt = t;
							o.unit = op - OP_WAIT_NS;
						end
						st = RS_PAUSED;
					end
					OP_PWAIT_A, OP_PWAIT_B: ;
					OP_LOOP: begin
						if (lvl + 1 >= CTX_DEPTH) begin
							st = RS_STOPPED;
						end else begin
							lvl++;
							lst[lvl] = r.now;
							dv[lvl] = 0;
							lcnt[lvl] = 0;
							lsp[lvl] = ip;
						end
					end
					OP_FOREVER: ip = lsp[lv];
					OP_UNT_CNT: begin
						t = byte_at(ip);
						ip++;
						c = lcnt[lv];
						lcnt[lv] = (c + 1) & 8'hFF;
						repeat_or_leave(c < t);
					end
					OP_UNT_LO_A, OP_UNT_LO_B: begin
						t = byte_at(ip);
						ip++;
						repeat_or_leave(pin_on(r.pins, t) != 0);
					end
					OP_UNT_HI_A, OP_UNT_HI_B: begin
						t = byte_at(ip);
						ip++;
						repeat_or_leave(pin_on(r.pins, t) != 1);
					end
					OP_UNT_NS, OP_UNT_NS + 1, OP_UNT_NS + 2, OP_UNT_NS + 3, OP_UNT_NS + 4,
					OP_UNT_HR: begin
						t = (byte_at(ip) << 8) | byte_at(ip + 1);
						ip += 2;
						if (!dv[lv]) begin
							ldl[lv] = lst[lv] + longint'(t) * NS_PER_UNIT[op - OP_UNT_NS];
							dv[lv] = 1;
						end
						repeat_or_leave(ldl[lv] > {1'b0, r.now});
					end
					default: st = RS_STOPPED;
				endcase
				if (ip >= PROG_BYTES) st = RS_STOPPED;
				ip &= 8'hFF;
			end
			default: ;
		endcase
		o.rs = st;
		return o;
	endfunction

	// Called at a rising edge; returns once the request is taken and any idle pause ends.
	task automatic send(input req_t r, input bit typed = 0, input res_t ex = '{default: '0});
		res_t p;
		start <= 1'b1;
		action <= r.act;
		prog_addr <= r.addr;
		prog_byte <= r.data;
		pin_levels <= r.pins;
		now_ns <= r.now;
		do @(posedge clk); while (busy);
		p = step_sequencer(r);
		pending_results.push_back(typed ? ex : p);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_limits(input int unsigned lo, input int unsigned hi,
			input int unsigned dflt);
		logic [1:0] idx [3];
		int unsigned v [3];
		idx = '{CFG_MIN, CFG_MAX, CFG_DEF};
		v = '{lo, hi, dflt};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= v[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		min_idx = lo;
		max_idx = hi;
		def_idx = dflt;
	endtask

	function automatic req_t mk(input logic [2:0] a, input logic [7:0] ad = 0,
			input logic [7:0] d = 0);
		req_t r;
		r.act = a;
		r.addr = ad;
		r.data = d;
		r.pins = {$urandom};
		if ($urandom_range(0, 9) == 0) now_cur = {$urandom, $urandom} >> 1;
		else if ($urandom_range(0, 6) == 0) now_cur += $urandom_range(0, 1000000000);
		else now_cur += $urandom_range(0, 5000);
		r.now = now_cur[62:0];
		return r;
	endfunction

	task automatic add_row(input logic [2:0] a, input logic [7:0] ad, input logic [7:0] d,
			input bit typed, input logic [2:0] c = CMD_NONE, input logic [7:0] arg = 0,
			input logic [21:0] cnt = 0, input logic [1:0] u = 0,
			input logic [1:0] rs = RS_STOPPED);
		row_t w;
		w.rq = mk(a, ad, d);
		w.typed = typed;
		w.ex = '{c, arg, cnt, u, rs};
		directed.push_back(w);
	endtask

	function automatic logic [7:0] random_opcode;
		int unsigned op;
		if ($urandom_range(0, 99) < 4) return $urandom_range(30, 255);
		op = $urandom_range(0, 29);
		if (op == OP_END && $urandom_range(0, 3) != 0) op = OP_EXP_P2;
		return op;
	endfunction

	task automatic run_program;
		logic [7:0] code [$];
		logic [7:0] op;
		int len;
		len = $urandom_range(4, 24);
		while (code.size() < len) begin
			op = random_opcode();
			code.push_back(op);
			case (op)
				OP_SET_SH: code.push_back($urandom_range(0, 255));
				OP_PIN_LO, OP_PIN_HI, OP_UNT_LO_A, OP_UNT_LO_B, OP_UNT_HI_A, OP_UNT_HI_B:
					code.push_back($urandom_range(0, 40));
				OP_UNT_CNT: code.push_back($urandom_range(0, 4));
				OP_WAIT_NS, OP_WAIT_US, OP_WAIT_MS, OP_WAIT_S, OP_WAIT_MIN: begin
					code.push_back($urandom_range(0, 255));
					code.push_back($urandom_range(0, 255));
				end
				default: if (op >= OP_UNT_NS && op <= OP_UNT_HR) begin
					code.push_back(0);
					code.push_back($urandom_range(0, 20));
				end
			endcase
		end
		code.push_back(OP_END);
		// Mostly the program itself, with the odd write anywhere in the address range.
		foreach (code[i]) begin
			send(mk(ACT_WRITE, i, code[i]));
			reqs_done++;
			if ($urandom_range(0, 15) == 0) begin
				send(mk(ACT_WRITE, $urandom_range(0, 255), $urandom_range(0, 255)));
				reqs_done++;
			end
		end
		send(mk(ACT_START));
		reqs_done++;
		programs_run++;
		for (int k = 0; k < 40; k++) begin
			int unsigned r;
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send(mk(ACT_STOP));
			end else if (r < 4) begin
				send(mk($urandom_range(5, 7)));
				continue;
			end else if (st == RS_PAUSED) begin
				send(mk(r < 90 ? ACT_TIMER : ACT_EXEC));
			end else if (st == RS_RUNNING) begin
				send(mk(r < 95 ? ACT_EXEC : ACT_TIMER));
			end else begin
				send(mk(ACT_EXEC));
				reqs_done++;
				break;
			end
			reqs_done++;
		end
	endtask

	initial begin
		int unsigned lims [6][3];
		errors = 0;
		results_seen = 0;
		cycles = 0;
		reqs_done = 0;
		programs_run = 0;
		quiet = 0;
		now_cur = 0;
		arst_n = 1'b0;
		start = 1'b0;
		action = ACT_WRITE;
		prog_addr = '0;
		prog_byte = '0;
		pin_levels = '0;
		now_ns = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MIN;
		cfg_data = '0;
		foreach (pmem[i]) pmem[i] = OP_END;
		ip = 0;
		st = RS_STOPPED;
		sh = 0;
		lvl = 0;
		foreach (dv[i]) begin
			dv[i] = 0;
			lsp[i] = 0;
			lcnt[i] = 0;
			lst[i] = 0;
			ldl[i] = 0;
		end
		min_idx = 0;
		max_idx = 60;
		def_idx = 30;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with the reset limits still in place.
		add_row(ACT_EXEC, 0, 0, 1);
		add_row(ACT_TIMER, 0, 0, 1);
		add_row(ACT_STOP, 0, 0, 1, CMD_CANCEL);
		add_row(3'd7, 8'hFF, 8'hFF, 1);
		add_row(ACT_WRITE, 8'hFF, 8'hAA, 1);
		add_row(ACT_WRITE, 0, OP_EXP_P3, 1);
		add_row(ACT_WRITE, 1, OP_CAMERA, 1);
		add_row(ACT_WRITE, 2, OP_PIN_HI, 1);
		add_row(ACT_WRITE, 3, 8'd31, 1);
		add_row(ACT_WRITE, 4, OP_WAIT_MIN, 1);
		add_row(ACT_WRITE, 5, 8'hFF, 1);
		add_row(ACT_WRITE, 6, 8'hFF, 1);
		add_row(ACT_WRITE, 7, OP_LOOP, 1);
		add_row(ACT_WRITE, 8, OP_UNT_CNT, 1);
		add_row(ACT_WRITE, 9, 8'd1, 1);
		add_row(ACT_WRITE, 10, OP_EXP_M3, 1);
		add_row(ACT_WRITE, 11, 8'd200, 1);
		add_row(ACT_START, 0, 0, 1, CMD_NONE, 0, 0, 0, RS_RUNNING);
		add_row(ACT_EXEC, 0, 0, 0);
		add_row(ACT_EXEC, 0, 0, 1, CMD_CAMERA, 8'd33, 0, 0, RS_PAUSED);
		add_row(ACT_TIMER, 0, 0, 0);
		add_row(ACT_EXEC, 0, 0, 1, CMD_PIN_HI, 8'd31, 0, 0, RS_RUNNING);
		add_row(ACT_EXEC, 0, 0, 1, CMD_WAIT, 0, 22'd3932100, 2'd3, RS_PAUSED);
		add_row(ACT_TIMER, 0, 0, 0);
		for (int i = 0; i < 4; i++) add_row(ACT_EXEC, 0, 0, 0);
		add_row(ACT_EXEC, 0, 0, 1);
		foreach (directed[i]) send(directed[i].rq, directed[i].typed, directed[i].ex);
		drain();

		lims = '{'{0, 60, 30}, '{0, 255, 255}, '{255, 255, 0}, '{10, 20, 15},
			'{0, 0, 0}, '{$urandom_range(0, 40), $urandom_range(40, 255), $urandom_range(0, 255)}};
		for (int ph = 0; ph < 6; ph++) begin
			set_limits(lims[ph][0], lims[ph][1], lims[ph][2]);
			while (reqs_done < RANDOM_REQS * (ph + 1) / 6) begin
				quiet = reqs_done > RANDOM_REQS * 85 / 100;
				run_program();
			end
			drain();
		end

		repeat (30) @(posedge clk);
		$display("ran %0d random programs over %0d requests under 6 shutter limit settings",
			programs_run, reqs_done);
		$display("%0d results checked, %0d mismatches", results_seen, errors);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("trigger_sequence_interpreter_unit_tb: clean");
		end else begin
			$display("trigger_sequence_interpreter_unit_tb: errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/tsi_pkg.sv
rtl/tsi_prog_mem.sv
rtl/tsi_mul.sv
rtl/trigger_sequence_interpreter_unit.sv
rtl/tsi_chk.sv
verif/trigger_sequence_interpreter_unit_tb.sv
